>>> sv/ring_range_smoothness_unit_macros.svh
// assertion macros for the ring range smoothness unit
`ifndef RING_RANGE_SMOOTHNESS_UNIT_MACROS_SVH
`define RING_RANGE_SMOOTHNESS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRS_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("rrs check");
`define RRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("rrs check");
`else
`define RRS_ASSERT_IMPL(label, clk, rst, cond)
`define RRS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> sv/rrs_pkg.sv
`default_nettype none
package rrs_pkg;
   localparam int HalfWindow = 5;
   localparam int WinLen = 2 * HalfWindow + 1;
   localparam int HeadLen = 2 * HalfWindow;
   localparam int MaxColumns = 2048;
   localparam int RangeW = 17;
   localparam int ColW = 11;
   localparam int CntW = 4;
   localparam int SumW = RangeW + CntW;
   localparam int BaseW = RangeW + CntW;
   localparam int SqW = 2 * SumW;
   localparam int DivSteps = SqW;
   localparam int StepW = 6;
   localparam logic [0:0] CsrColumnCount = 1'b0;
   localparam logic [0:0] CsrMinValidRange = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_GATHER, ST_MUL, ST_SQR, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SqW-1:0]   dividend;
      logic [BaseW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

>>> sv/rrs_divider.sv
`default_nettype none
`include "ring_range_smoothness_unit_macros.svh"
// restoring divider, one quotient bit per cycle, saturating to 32 bits
module rrs_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrs_pkg::div_req_type req,
   output rrs_pkg::div_rsp_type      rsp
);
   logic [rrs_pkg::SqW-1:0]   dvd_ff, dvd_in;
   logic [rrs_pkg::BaseW:0]   rem_ff, rem_in;
   logic [rrs_pkg::BaseW-1:0] dsr_ff, dsr_in;
   logic [rrs_pkg::StepW-1:0] step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      zero_ff, zero_in;
   logic [rrs_pkg::BaseW:0]   trial;
   logic                      sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      trial   = {rem_ff[rrs_pkg::BaseW-1:0], dvd_ff[rrs_pkg::SqW-1]};
      if (req.start) begin
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         // zero over zero gives zero
         zero_in = (req.dividend == '0);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[rrs_pkg::SqW-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in    = trial - {1'b0, dsr_ff};
            dvd_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == rrs_pkg::StepW'(rrs_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // after the run the dividend register holds the quotient
   assign sat = (|dvd_ff[rrs_pkg::SqW-1:32]) || (dsr_ff == '0 && dvd_ff != '0);
   assign rsp.done = done_ff;
   assign rsp.quotient = zero_ff ? 32'h0 : (sat ? 32'hFFFF_FFFF : dvd_ff[31:0]);

   `RRS_ASSERT_NEXT(div_start_busy, clock, reset, req.start, busy_ff)
   `RRS_ASSERT_IMPL(div_done_idle, clock, reset, !(done_ff && busy_ff))
   `RRS_ASSERT_NEXT(div_done_pulse, clock, reset, done_ff, !done_ff)
endmodule
`default_nettype wire

>>> sv/ring_range_smoothness_unit.sv
`default_nettype none
`include "ring_range_smoothness_unit_macros.svh"
// Ring range smoothness: ranges of one ring row come in column order, one request
// each; every column with a present range and a present neighbour gets the squared
// deviation from its five neighbours on each side (wrapping around the row) over count
// times range. A column's result follows once its right neighbours have arrived; the
// last request of a row releases the ten wrapped columns too. The eleven window taps
// are gathered one per cycle, the MUL state forms count times range and the difference,
// the SQR state squares it in a 21x21 multiply, the restoring divider forms its 42
// quotient bits, and the OUT state presents the result; a missing result goes from MUL
// straight to OUT. One request is in work at a time; req_stall is high until all its
// results are taken.
module ring_range_smoothness_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [16:0] req_range_mm,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [10:0]      rsp_column_index,
   output logic             rsp_smooth_valid,
   output logic [31:0]      rsp_smoothness,
   output logic             rsp_last_of_row,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   localparam int RW = rrs_pkg::RangeW;
   localparam int CW = rrs_pkg::ColW;

   rrs_pkg::state_type state_ff, state_in;
   logic [11:0]   ncol_ff;
   logic [RW-1:0] minr_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] win_ff [rrs_pkg::WinLen];
   logic [RW-1:0] head_ff [rrs_pkg::HeadLen];
   // emission list: number of results left and current center column
   logic [3:0]    left_ff, left_in;
   logic [CW-1:0] ctr_ff, ctr_in;
   logic [CW-1:0] newest_ff, newest_in;
   logic [3:0]    tap_ff, tap_in;
   logic [RW-1:0] cr_ff, cr_in;
   logic [rrs_pkg::SumW-1:0] sum_ff, sum_in;
   logic [rrs_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [rrs_pkg::SumW-1:0] ad_ff, ad_in;
   logic [rrs_pkg::BaseW-1:0] base_ff, base_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic          ovld_ff, ovld_in, olast_ff, olast_in;
   logic [31:0]   oq_ff, oq_in;
   rrs_pkg::div_req_type dreq;
   rrs_pkg::div_rsp_type drsp;

   logic [CW:0]   n_eff;
   logic [CW-1:0] nm1;
   logic [CW-1:0] col_j;
   logic          accept;
   logic [CW:0]   tcol;
   logic [CW-1:0] tc;
   logic [RW-1:0] tv;
   logic [CW-1:0] tap_age;
   logic [rrs_pkg::SumW-1:0] base_w;

   // clamp columns per row
   always_comb begin
      if (ncol_ff < 12'(rrs_pkg::WinLen)) n_eff = 12'(rrs_pkg::WinLen);
      else if (ncol_ff > 12'(rrs_pkg::MaxColumns)) n_eff = 12'(rrs_pkg::MaxColumns);
      else n_eff = ncol_ff;
      nm1 = CW'(n_eff - 1'b1);
   end

   // column of the incoming request
   assign col_j = (col_ff > nm1) ? nm1 : col_ff;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != rrs_pkg::ST_IDLE);

   // tap column: center-5 .. center+5 modulo n
   always_comb begin
      tcol = {1'b0, ctr_ff} + 12'(tap_ff);
      if (tcol < 12'(rrs_pkg::HalfWindow)) tcol = tcol + n_eff - 12'(rrs_pkg::HalfWindow);
      else tcol = tcol - 12'(rrs_pkg::HalfWindow);
      if (tcol >= n_eff) tcol = tcol - n_eff;
      tc = tcol[CW-1:0];
      tap_age = newest_ff - tc;
      if (tc <= newest_ff && tap_age < CW'(rrs_pkg::WinLen)) tv = win_ff[tap_age[3:0]];
      else if (tc < CW'(rrs_pkg::HeadLen)) tv = head_ff[tc[3:0]];
      else tv = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrs_pkg::ST_IDLE;
         ncol_ff  <= 12'd1808;
         minr_ff  <= 17'd10;
         col_ff   <= '0;
         for (int i = 0; i < rrs_pkg::WinLen; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         if (csr_write) begin
            unique case (csr_index)
               rrs_pkg::CsrColumnCount: ncol_ff <= csr_data[11:0];
               rrs_pkg::CsrMinValidRange: minr_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            for (int i = rrs_pkg::WinLen - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
            win_ff[0] <= req_range_mm;
         end
      end
      if (accept && col_j < CW'(rrs_pkg::HeadLen))
         head_ff[col_j[3:0]] <= req_range_mm;
      left_ff <= left_in; ctr_ff <= ctr_in; newest_ff <= newest_in;
      tap_ff <= tap_in; cr_ff <= cr_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
      ad_ff <= ad_in; base_ff <= base_in; ocol_ff <= ocol_in;
      ovld_ff <= ovld_in; olast_ff <= olast_in; oq_ff <= oq_in;
   end

   assign base_w = rrs_pkg::SumW'(cnt_ff) * rrs_pkg::SumW'(cr_ff);

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      left_in = left_ff; ctr_in = ctr_ff; newest_in = newest_ff;
      tap_in = tap_ff; cr_in = cr_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      ad_in = ad_ff; base_in = base_ff; ocol_in = ocol_ff;
      ovld_in = ovld_ff; olast_in = olast_ff; oq_in = oq_ff;
      dreq.start = 1'b0;
      dreq.dividend = rrs_pkg::SqW'(ad_ff) * rrs_pkg::SqW'(ad_ff);
      dreq.divisor = base_ff;
      unique case (state_ff)
         rrs_pkg::ST_IDLE: begin
            if (accept) begin
               newest_in = col_j;
               col_in = (col_j == nm1) ? '0 : col_j + 1'b1;
               // wrap list starts at n-5 and runs ten columns
               if (col_j == nm1) left_in = 4'd11;
               else left_in = 4'd1;
               if (col_j >= CW'(rrs_pkg::HeadLen)) begin
                  ctr_in = col_j - CW'(rrs_pkg::HalfWindow);
               end else begin
                  ctr_in = nm1 - CW'(rrs_pkg::HalfWindow - 1);
                  left_in = left_in - 1'b1;
               end
               tap_in = '0; sum_in = '0; cnt_in = '0;
               if (left_in != 0) state_in = rrs_pkg::ST_GATHER;
            end
         end
         rrs_pkg::ST_GATHER: begin
            if (tap_ff == 4'(rrs_pkg::HalfWindow)) cr_in = tv;
            else if (tv >= minr_ff) begin
               sum_in = sum_ff + rrs_pkg::SumW'(tv);
               cnt_in = cnt_ff + 1'b1;
            end
            tap_in = tap_ff + 1'b1;
            if (tap_ff == 4'(rrs_pkg::WinLen - 1)) state_in = rrs_pkg::ST_MUL;
         end
         rrs_pkg::ST_MUL: begin
            base_in = base_w;
            ad_in = (sum_ff >= base_w) ? sum_ff - base_w : base_w - sum_ff;
            ocol_in = ctr_ff;
            olast_in = (left_ff == 4'd1) && (newest_ff == nm1);
            ovld_in = (cr_ff >= minr_ff) && (cnt_ff != 0);
            oq_in = '0;
            state_in = ovld_in ? rrs_pkg::ST_SQR : rrs_pkg::ST_OUT;
         end
         rrs_pkg::ST_SQR: begin
            // square of the registered difference starts the divider
            dreq.start = 1'b1;
            state_in = rrs_pkg::ST_DIV;
         end
         rrs_pkg::ST_DIV: begin
            if (drsp.done) begin
               oq_in = drsp.quotient;
               state_in = rrs_pkg::ST_OUT;
            end
         end
         rrs_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               left_in = left_ff - 1'b1;
               ctr_in = (ctr_ff == nm1) ? '0 : ctr_ff + 1'b1;
               tap_in = '0; sum_in = '0; cnt_in = '0;
               state_in = (left_ff == 4'd1) ? rrs_pkg::ST_IDLE : rrs_pkg::ST_GATHER;
            end
         end
         default: state_in = rrs_pkg::ST_IDLE;
      endcase
      // a new column count starts a new row
      if (csr_write && csr_index == rrs_pkg::CsrColumnCount) col_in = '0;
   end

   rrs_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign rsp_valid = (state_ff == rrs_pkg::ST_OUT);
   assign rsp_column_index = ocol_ff;
   assign rsp_smooth_valid = ovld_ff;
   assign rsp_smoothness = oq_ff;
   assign rsp_last_of_row = olast_ff;

   `RRS_ASSERT_IMPL(out_zero_invalid, clock, reset, !(rsp_valid && !rsp_smooth_valid && rsp_smoothness != 0))
   `RRS_ASSERT_NEXT(out_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_smoothness))
   `RRS_ASSERT_IMPL(no_accept_busy, clock, reset, !(accept && state_ff != rrs_pkg::ST_IDLE))
endmodule
`default_nettype wire
